// File: sv/mqrr_pkg.sv
// ----------------------------------------------------------------------------
// mqrr_pkg
// Shared types and constants of the round-robin multi-queue dispatcher.
// ----------------------------------------------------------------------------
package mqrr_pkg;

	localparam int NUM_QUEUES   = 8;
	localparam int QUEUE_DEPTH  = 16;
	localparam int HANDLE_WIDTH = 32;
	localparam int QW = $clog2(NUM_QUEUES);
	localparam int DW = $clog2(QUEUE_DEPTH);
	localparam int CW = DW + 1;
	localparam int SW = QW + DW;
	localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;

	localparam logic [1:0] REQ_ADD      = 2'd0;
	localparam logic [1:0] REQ_DISPATCH = 2'd1;
	localparam logic [1:0] REQ_COMPLETE = 2'd2;

	localparam logic [1:0] REG_ACCEPT = 2'd0;
	localparam logic [1:0] REG_MASK   = 2'd1;
	localparam logic [1:0] REG_LIMITS = 2'd2;

	localparam logic [3:0] ST_QUEUED     = 4'd0;
	localparam logic [3:0] ST_DISPATCHED = 4'd1;
	localparam logic [3:0] ST_COMPLETED  = 4'd2;
	localparam logic [3:0] ST_NO_QUEUE   = 4'd3;
	localparam logic [3:0] ST_NONE       = 4'd4;
	localparam logic [3:0] ST_LIMIT      = 4'd5;
	localparam logic [3:0] ST_CLOSED     = 4'd6;
	localparam logic [3:0] ST_NULL       = 4'd7;
	localparam logic [3:0] ST_FULL       = 4'd8;
	localparam logic [3:0] ST_UNDERFLOW  = 4'd9;

	// one request as passed from front to back
	typedef struct packed {
		logic [1:0]  req;
		logic [2:0]  qid;
		logic [31:0] handle;
	} req_t;

endpackage

// File: sv/multi_queue_round_robin_dispatcher_unit.sv
// ----------------------------------------------------------------------------
// multi_queue_round_robin_dispatcher_unit
// Round-robin dispatcher over eight task FIFOs with per-queue in-flight limits.
// ----------------------------------------------------------------------------
// Usage:
//  - Pulse start with req_type, queue_id and task_handle while busy is low;
//    the request is transferred at that edge.
//  - A front queue of two entries holds requests; the back end executes one.
//  - Add, completion and refused requests report in the cycle after they
//    leave the front queue; a dispatch reports after its registered task
//    store read. Sustained rate: one request per cycle for add, completion
//    and refused requests; a dispatch holds the next one until its read ends.
//  - Each result shows for exactly one cycle with done high; the receiver
//    cannot stall, so results are never held.
//  - Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
//    the user makes them only while the block is idle; the block does not enforce it.
//  - Reset clears all queues, counters, pointer and registers; the task store
//    itself is not cleared.
// ----------------------------------------------------------------------------
module multi_queue_round_robin_dispatcher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [2:0]  queue_id,
	input  logic [31:0] task_handle,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output logic        done,
	output logic [3:0]  status,
	output logic [2:0]  granted_queue,
	output logic [31:0] granted_handle,
	output logic        any_pending
);
	import mqrr_pkg::*;

	req_t head;
	logic head_valid;
	logic pop;

	mqrr_front u_front (
		.clk, .arst_n, .start, .req_type, .queue_id, .task_handle,
		.busy, .head, .head_valid, .pop
	);

	mqrr_back u_back (
		.clk, .arst_n, .head, .head_valid, .pop, .cfg_we, .cfg_index, .cfg_data,
		.done, .status, .granted_queue, .granted_handle, .any_pending
	);

endmodule

// File: sv/mqrr_front.sv
// ----------------------------------------------------------------------------
// mqrr_front
// Accepts requests and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module mqrr_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     req_type,
	input  logic [2:0]     queue_id,
	input  logic [31:0]    task_handle,
	output logic           busy,
	output mqrr_pkg::req_t head,
	output logic           head_valid,
	input  logic           pop
);
	import mqrr_pkg::*;

	req_t       fifo_q [2];
	logic       rd_q;
	logic       wr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign busy       = (cnt_q == 2'd2);
	assign push       = start && !busy;
	assign head_valid = (cnt_q != 2'd0);
	assign head       = fifo_q[rd_q];

	// write payload
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= '{req: req_type, qid: queue_id, handle: task_handle};
		end
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: sv/mqrr_back.sv
// ----------------------------------------------------------------------------
// mqrr_back
// Executes add, dispatch and completion against the queue state and applies configuration writes.
// ----------------------------------------------------------------------------
module mqrr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  mqrr_pkg::req_t head,
	input  logic           head_valid,
	output logic           pop,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [63:0]    cfg_data,
	output logic           done,
	output logic [3:0]     status,
	output logic [2:0]     granted_queue,
	output logic [31:0]    granted_handle,
	output logic           any_pending
);
	import mqrr_pkg::*;

	logic [HANDLE_WIDTH-1:0] store_q [STORE_DEPTH];
	logic [DW-1:0]  head_idx_q [NUM_QUEUES];
	logic [CW-1:0]  fill_q     [NUM_QUEUES];
	logic [7:0]     infl_q     [NUM_QUEUES];
	logic [QW-1:0]  rr_q;
	logic           accept_q;
	logic [7:0]     mask_q;
	logic [63:0]    limits_q;

	// stage 2: read pending
	logic           rd_s2;
	logic [HANDLE_WIDTH-1:0] rdata_s2;

	logic [NUM_QUEUES-1:0] en, nonempty;
	logic           found;
	logic [QW-1:0]  pick;
	logic           at_limit;
	logic [QW-1:0]  qid;
	logic [7:0]     lim;
	logic [3:0]     st;
	logic           do_add, do_disp, do_comp;
	logic [7:0]     nmask;

	assign qid = head.qid[QW-1:0];

	always_comb begin
		for (int q = 0; q < NUM_QUEUES; q++) begin
			en[q]       = (q == 0) ? 1'b1 : ((q < 8) ? mask_q[q] : 1'b0);
			nonempty[q] = en[q] && (fill_q[q] != '0);
		end
	end

	// rotating search after the pointer
	always_comb begin
		logic [QW-1:0] c;
		found = 1'b0;
		pick  = '0;
		for (int i = 1; i <= NUM_QUEUES; i++) begin
			c = QW'((32'(rr_q) + i) % NUM_QUEUES);
			if (!found && nonempty[c]) begin
				found = 1'b1;
				pick  = c;
			end
		end
		lim = limits_q[8*pick +: 8];
		at_limit = ((lim != 8'd0) && (infl_q[pick] >= lim)) || (infl_q[pick] == 8'hFF);
	end

	// classify the request at the head
	always_comb begin
		do_add  = 1'b0;
		do_disp = 1'b0;
		do_comp = 1'b0;
		st      = ST_NO_QUEUE;
		case (head.req)
			REQ_ADD: begin
				if (!accept_q) st = ST_CLOSED;
				else if (head.handle == '0) st = ST_NULL;
				else if (!(32'(head.qid) < NUM_QUEUES) || !en[qid]) st = ST_NO_QUEUE;
				else if (fill_q[qid] >= CW'(QUEUE_DEPTH)) st = ST_FULL;
				else begin
					st     = ST_QUEUED;
					do_add = 1'b1;
				end
			end
			REQ_DISPATCH: begin
				if (!found) st = ST_NONE;
				else if (at_limit) st = ST_LIMIT;
				else begin
					st      = ST_DISPATCHED;
					do_disp = 1'b1;
				end
			end
			REQ_COMPLETE: begin
				if (!(32'(head.qid) < NUM_QUEUES) || !en[qid]) st = ST_NO_QUEUE;
				else if (infl_q[qid] == 8'd0) st = ST_UNDERFLOW;
				else begin
					st      = ST_COMPLETED;
					do_comp = 1'b1;
				end
			end
			default: st = ST_NO_QUEUE;
		endcase
	end

	// hold the head while a dispatch read finishes
	assign pop   = head_valid && !rd_s2;
	assign nmask = cfg_data[7:0] | 8'h01;

	// task store
	always_ff @(posedge clk) begin
		if (pop && do_add) begin
			store_q[{qid, DW'(head_idx_q[qid] + fill_q[qid][DW-1:0])}] <= head.handle;
		end
		rdata_s2 <= store_q[{pick, head_idx_q[pick]}];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < NUM_QUEUES; q++) begin
				head_idx_q[q] <= '0;
				fill_q[q]     <= '0;
				infl_q[q]     <= '0;
			end
			rr_q     <= '0;
			accept_q <= 1'b0;
			mask_q   <= 8'h01;
			limits_q <= '0;
			rd_s2    <= 1'b0;
			done     <= 1'b0;
			status   <= '0;
			granted_queue  <= '0;
			granted_handle <= '0;
		end else begin
			done  <= 1'b0;
			rd_s2 <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_ACCEPT: accept_q <= cfg_data[0];
					REG_MASK: begin
						for (int q = 0; q < NUM_QUEUES && q < 8; q++) begin
							if (mask_q[q] && !nmask[q]) begin
								head_idx_q[q] <= '0;
								fill_q[q]     <= '0;
								infl_q[q]     <= '0;
							end
						end
						mask_q <= nmask;
					end
					REG_LIMITS: limits_q <= cfg_data;
					default: ;
				endcase
			end
			if (rd_s2) begin
				done           <= 1'b1;
				granted_handle <= rdata_s2;
			end
			if (pop) begin
				status        <= st;
				granted_queue <= do_disp ? 3'(pick) : head.qid;
				if (do_add) fill_q[qid] <= fill_q[qid] + 1'b1;
				if (do_comp) infl_q[qid] <= infl_q[qid] - 8'd1;
				if (do_disp) begin
					head_idx_q[pick] <= head_idx_q[pick] + 1'b1;
					fill_q[pick]     <= fill_q[pick] - 1'b1;
					infl_q[pick]     <= infl_q[pick] + 8'd1;
					rr_q             <= pick;
					rd_s2            <= 1'b1;
				end else begin
					done           <= 1'b1;
					granted_handle <= '0;
				end
			end
		end
	end

	// pending flag reflects state after the step
	always_comb begin
		any_pending = 1'b0;
		for (int q = 0; q < NUM_QUEUES; q++) begin
			if (en[q] && fill_q[q] != '0) any_pending = 1'b1;
		end
	end

endmodule

// File: sim/tb_multi_queue_round_robin_dispatcher_unit.sv
// ----------------------------------------------------------------------------
// tb_multi_queue_round_robin_dispatcher_unit
// Drives add, dispatch, completion and undefined requests into the dispatcher
// through several register settings. Predicts each response with a local queue
// model and compares every strobed response, field by field, in order.
// ----------------------------------------------------------------------------
module tb_multi_queue_round_robin_dispatcher_unit;
	import mqrr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REQ_UNDEFINED = 2'd3;

	typedef struct packed {
		logic [3:0]  status;
		logic [2:0]  queue;
		logic [31:0] handle;
		logic        pending;
	} resp_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  req_type;
	logic [2:0]  queue_id;
	logic [31:0] task_handle;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        done;
	logic [3:0]  status;
	logic [2:0]  granted_queue;
	logic [31:0] granted_handle;
	logic        any_pending;

	// model state
	logic        m_accept;
	logic [7:0]  m_mask;
	logic [63:0] m_limits;
	logic [31:0] m_store [NUM_QUEUES][QUEUE_DEPTH];
	int          m_head [NUM_QUEUES];
	int          m_fill [NUM_QUEUES];
	int          m_flight [NUM_QUEUES];
	int          m_ptr;

	req_t  pending_reqs [$];
	resp_t expected_resps [$];
	int    sender_idle;
	int    errors;
	int    cycles;

	multi_queue_round_robin_dispatcher_unit uut (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic bit queue_on(int q);
		return q == 0 || m_mask[q];
	endfunction

	function automatic void model_clear(int q);
		m_head[q] = 0;
		m_fill[q] = 0;
		m_flight[q] = 0;
	endfunction

	function automatic void model_write(logic [1:0] idx, logic [63:0] v);
		logic [7:0] nm;
		if (idx == REG_ACCEPT) begin
			m_accept = v[0];
		end else if (idx == REG_MASK) begin
			nm = v[7:0] | 8'd1;
			for (int q = 0; q < NUM_QUEUES; q++)
				if (m_mask[q] && !nm[q]) model_clear(q);
			m_mask = nm;
		end else if (idx == REG_LIMITS) begin
			m_limits = v;
		end
	endfunction

	// compute the response of one request and advance the model
	function automatic resp_t dispatch_predict(req_t r);
		resp_t o;
		int q;
		int lim;
		o.status = ST_NO_QUEUE;
		o.queue = r.qid;
		o.handle = '0;
		if (r.req == REQ_ADD) begin
			if (!m_accept) o.status = ST_CLOSED;
			else if (r.handle == 0) o.status = ST_NULL;
			else if (!queue_on(r.qid)) o.status = ST_NO_QUEUE;
			else if (m_fill[r.qid] >= QUEUE_DEPTH) o.status = ST_FULL;
			else begin
				m_store[r.qid][(m_head[r.qid] + m_fill[r.qid]) % QUEUE_DEPTH] = r.handle;
				m_fill[r.qid]++;
				o.status = ST_QUEUED;
			end
		end else if (r.req == REQ_DISPATCH) begin
			o.status = ST_NONE;
			for (int i = 1; i <= NUM_QUEUES; i++) begin
				q = (m_ptr + i) % NUM_QUEUES;
				if (!queue_on(q) || m_fill[q] == 0) continue;
				lim = m_limits[8*q +: 8];
				if ((lim != 0 && m_flight[q] >= lim) || m_flight[q] >= 255) begin
					o.status = ST_LIMIT;
				end else begin
					o.handle = m_store[q][m_head[q]];
					m_head[q] = (m_head[q] + 1) % QUEUE_DEPTH;
					m_fill[q]--;
					m_flight[q]++;
					m_ptr = q;
					o.queue = 3'(q);
					o.status = ST_DISPATCHED;
				end
				break;
			end
		end else if (r.req == REQ_COMPLETE) begin
			if (!queue_on(r.qid)) o.status = ST_NO_QUEUE;
			else if (m_flight[r.qid] == 0) o.status = ST_UNDERFLOW;
			else begin
				m_flight[r.qid]--;
				o.status = ST_COMPLETED;
			end
		end
		o.pending = 1'b0;
		for (int k = 0; k < NUM_QUEUES; k++)
			if (queue_on(k) && m_fill[k] != 0) o.pending = 1'b1;
		return o;
	endfunction

	// driver: transfer the oldest pending request, with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
			req_type <= '0;
			queue_id <= '0;
			task_handle <= '0;
		end else if (start && !busy) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle) begin
				expected_resps.push_back(dispatch_predict(pending_reqs[0]));
				req_type <= pending_reqs[0].req;
				queue_id <= pending_reqs[0].qid;
				task_handle <= pending_reqs[0].handle;
				void'(pending_reqs.pop_front());
			end else begin
				start <= 0;
			end
		end else if (!start && pending_reqs.size() != 0
				&& $urandom_range(99) >= sender_idle) begin
			expected_resps.push_back(dispatch_predict(pending_reqs[0]));
			start <= 1;
			req_type <= pending_reqs[0].req;
			queue_id <= pending_reqs[0].qid;
			task_handle <= pending_reqs[0].handle;
			void'(pending_reqs.pop_front());
		end
	end

	// monitor: check each strobed response against the oldest expectation
	always @(posedge clk) begin
		resp_t want;
		if (arst_n && done) begin
			if (expected_resps.size() == 0) begin
				$display("%0t unexpected response status %0d", $time, status);
				errors++;
			end else begin
				want = expected_resps.pop_front();
				if (status !== want.status) begin
					$display("%0t status exp %0d got %0d", $time, want.status, status);
					errors++;
				end
				if (granted_queue !== want.queue) begin
					$display("%0t queue exp %0d got %0d", $time, want.queue,
						granted_queue);
					errors++;
				end
				if (granted_handle !== want.handle) begin
					$display("%0t handle exp %h got %h", $time, want.handle,
						granted_handle);
					errors++;
				end
				if (any_pending !== want.pending) begin
					$display("%0t pending exp %0d got %0d", $time, want.pending,
						any_pending);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("FAIL multi_queue_round_robin_dispatcher_unit");
			$finish;
		end
	end

	task automatic add_req(logic [1:0] rq, logic [2:0] q, logic [31:0] h);
		req_t r;
		r.req = rq;
		r.qid = q;
		r.handle = h;
		pending_reqs.push_back(r);
	endtask

	// hold until everything sent has answered, then let the pipeline drain
	task automatic wait_idle();
		while (pending_reqs.size() != 0 || start || expected_resps.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [63:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		model_write(idx, v);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [31:0] rand_handle();
		case ($urandom_range(5))
			0: return 32'hFFFF_FFFF;
			1: return 32'd1;
			2: return 32'd0;
			default: return $urandom;
		endcase
	endfunction

	// random phase: a random mix of adds, dispatches, completions and undefined requests
	task automatic random_phase(int n);
		int k;
		k = 0;
		while (k < n) begin
			case ($urandom_range(9))
				0, 1, 2, 3: add_req(REQ_ADD, 3'($urandom_range(7)), rand_handle());
				4, 5, 6: add_req(REQ_DISPATCH, 3'($urandom_range(7)), $urandom);
				7, 8: add_req(REQ_COMPLETE, 3'($urandom_range(7)), $urandom);
				default: add_req(REQ_UNDEFINED, 3'($urandom_range(7)), $urandom);
			endcase
			k++;
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		sender_idle = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 0;
		m_accept = 0;
		m_mask = 8'd1;
		m_limits = '0;
		m_ptr = 0;
		for (int q = 0; q < NUM_QUEUES; q++) model_clear(q);
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: closed, nothing pending, underflow, undefined request
		add_req(REQ_ADD, 0, 32'h1234);
		add_req(REQ_DISPATCH, 0, 0);
		add_req(REQ_COMPLETE, 0, 0);
		add_req(REQ_UNDEFINED, 5, 32'hFFFF_FFFF);
		wait_idle();
		reg_write(REG_ACCEPT, 64'd1);
		reg_write(REG_MASK, 64'h05);
		reg_write(REG_LIMITS, 64'h0000_0000_0000_0101);
		// null, disabled queue, limit reached, round robin
		add_req(REQ_ADD, 0, 32'd0);
		add_req(REQ_ADD, 1, 32'hAAAA);
		add_req(REQ_ADD, 0, 32'hFFFF_FFFF);
		add_req(REQ_ADD, 0, 32'd1);
		add_req(REQ_ADD, 2, 32'h5555_5555);
		add_req(REQ_DISPATCH, 7, 0);
		add_req(REQ_DISPATCH, 0, 0);
		add_req(REQ_DISPATCH, 0, 0);
		add_req(REQ_COMPLETE, 0, 0);
		add_req(REQ_DISPATCH, 0, 0);
		add_req(REQ_COMPLETE, 1, 0);
		// fill queue 2 past full
		for (int i = 0; i < 17; i++) add_req(REQ_ADD, 2, 32'h100 + i);
		wait_idle();

		// random phases through several settings
		sender_idle = 19;
		reg_write(REG_MASK, 64'hFF);
		reg_write(REG_LIMITS, 64'h0);
		random_phase(300);
		wait_idle();
		sender_idle = 68;
		reg_write(REG_LIMITS, 64'hFFFF_FFFF_FFFF_FFFF);
		reg_write(REG_MASK, 64'hA6);
		random_phase(250);
		wait_idle();
		sender_idle = 0;
		reg_write(REG_LIMITS, {$urandom, $urandom});
		reg_write(REG_MASK, 64'h5B);
		random_phase(250);
		wait_idle();
		reg_write(REG_ACCEPT, 64'd0);
		reg_write(REG_MASK, 64'hFF);
		reg_write(REG_LIMITS, 64'h0303_0303_0303_0303);
		random_phase(60);
		wait_idle();
		reg_write(REG_ACCEPT, 64'd1);
		random_phase(180);
		wait_idle();

		repeat (10) @(posedge clk);
		if (errors == 0 && expected_resps.size() == 0) begin
			$display("PASS multi_queue_round_robin_dispatcher_unit");
		end else begin
			$display("FAIL multi_queue_round_robin_dispatcher_unit");
		end
		$finish;
	end

endmodule

// File: multi_queue_round_robin_dispatcher_unit.f
sv/mqrr_pkg.sv
sv/mqrr_front.sv
sv/mqrr_back.sv
sv/multi_queue_round_robin_dispatcher_unit.sv
sim/tb_multi_queue_round_robin_dispatcher_unit.sv
